// File: src/btil_pkg.sv
// btil_pkg: shared types and constants for the bitmap to index list decoder
// no dependencies; imported by every module of the block

package btil_pkg;

   localparam int INDEX_BITS  = 20;                 // width of a surface index
   localparam int BASE_W      = INDEX_BITS + 1;     // base index, saturates at 2^INDEX_BITS
   localparam int AMT_W       = 11;                 // largest advance is 255 * 8
   localparam int SUM_W       = INDEX_BITS + 12;    // base plus advance without wrap
   localparam int BYTE_SPAN   = 8;                  // indices covered by one bitmap byte
   localparam int JOB_Q_DEPTH = 4;                  // jobs between front and back end

   localparam logic [SUM_W-1:0] IDX_LIMIT = SUM_W'(1) << INDEX_BITS;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       section_end;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] surface_index;
      logic                  has_index;
      logic                  run_last;
      logic                  section_done;
      logic                  index_overflow;
   } rsp_type;

   // one classified byte: an empty mask means an end marker
   typedef struct packed {
      logic [INDEX_BITS-1:0] base;
      logic [7:0]            mask;
      logic                  last;
      logic                  ovf;
   } job_type;

endpackage

// File: src/bitmap_to_index_list_decoder.sv
// bitmap_to_index_list_decoder: top level, visibility bitmap bytes to surface indices
// depends on btil_pkg, btil_front, btil_job_fifo, btil_back
//
//   channel   ports                      transaction
//   input     push, full, req_data       one bitmap byte plus section end flag
//   result    pop, empty, rsp_data       one surface index or end marker
//   csr       csr_we, csr_wdata          compressed_mode, written at once
//
// the front end takes a byte every cycle while the job queue has room and
// updates base, run and overflow state in that same cycle
// the back end sends one result per cycle while the result port is not stalled;
// k visible bits in a byte give k results (8 at most), an end marker one
// first result of a byte goes via job queue, current job register, output register
// synchronous active-high reset clears state and queue, compressed_mode returns to 1
// a stalled result port fills the four-entry job queue, then full rises

module bitmap_to_index_list_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  btil_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output btil_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);
   import btil_pkg::*;

   logic    accept;      // input transaction this cycle
   logic    job_push;    // front end has a job for the queue
   job_type job_in;
   logic    job_valid;   // queue head present
   job_type job_head;
   logic    job_pop;     // back end takes the head

   assign accept = push && !full;

   // classify bytes, keep per-section state
   btil_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .job_push  (job_push),
      .job       (job_in)
   );

   // decouples byte intake from result expansion
   btil_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_push),
      .wr_job   (job_in),
      .full     (full),
      .rd_en    (job_pop),
      .rd_valid (job_valid),
      .rd_job   (job_head)
   );

   // one result per cycle into the output register while the result port is not stalled
   btil_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job_head),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/btil_front.sv
// btil_front: takes bitmap bytes, keeps base index, run and overflow state
// depends on btil_pkg; emits one job per byte that produces any result

module btil_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             accept,
   input  btil_pkg::req_type req_data,
   output logic             job_push,
   output btil_pkg::job_type job
);
   import btil_pkg::*;

   logic [BASE_W-1:0] base_ff, base_in;
   logic              pending_ff, pending_in;
   logic              ovf_ff, ovf_in;
   logic              mode_ff;

   logic [AMT_W-1:0]  amount;
   logic [SUM_W-1:0]  sum;
   logic              do_adv;
   logic              adv_ovf;
   logic              bit_ovf;
   logic [7:0]        mask;
   logic [BASE_W-1:0] probe [8];
   logic              byte_zero;

   assign byte_zero = (req_data.data_byte == 8'd0);

   // per-bit range check against the saturated base
   always_comb begin
      mask    = '0;
      bit_ovf = 1'b0;
      for (int j = 0; j < 8; j++) begin
         probe[j] = base_ff + BASE_W'(j);
         if (!pending_ff && req_data.data_byte[j]) begin
            if (probe[j][INDEX_BITS]) begin
               bit_ovf = 1'b1;
            end else begin
               mask[j] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      amount  = pending_ff ? {req_data.data_byte, 3'b000} : AMT_W'(BYTE_SPAN);
      do_adv  = pending_ff || !byte_zero || !mode_ff;
      sum     = SUM_W'(base_ff) + SUM_W'(amount);
      adv_ovf = do_adv && (sum > IDX_LIMIT);
      ovf_in  = ovf_ff || bit_ovf || adv_ovf;
      if (!do_adv) begin
         base_in = base_ff;
      end else if (adv_ovf) begin
         base_in = IDX_LIMIT[BASE_W-1:0];
      end else begin
         base_in = sum[BASE_W-1:0];
      end
      pending_in = !pending_ff && byte_zero && mode_ff && !req_data.section_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         pending_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         mode_ff    <= 1'b1;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (accept) begin
            if (req_data.section_end) begin
               base_ff    <= '0;
               pending_ff <= 1'b0;
               ovf_ff     <= 1'b0;
            end else begin
               base_ff    <= base_in;
               pending_ff <= pending_in;
               ovf_ff     <= ovf_in;
            end
         end
      end
   end

   assign job_push = accept && ((mask != 8'd0) || req_data.section_end);
   assign job.base = base_ff[INDEX_BITS-1:0];
   assign job.mask = mask;
   assign job.last = req_data.section_end;
   assign job.ovf  = ovf_in;

`ifndef SYNTH
   a_base_sat: assert property (@(posedge clock) disable iff (reset)
      base_ff <= IDX_LIMIT[BASE_W-1:0])
      else $error("base index beyond saturation limit");
   a_section_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.section_end |=> (base_ff == '0) && !pending_ff && !ovf_ff)
      else $error("section state not cleared at section end");
`endif

endmodule

// File: src/btil_job_fifo.sv
// btil_job_fifo: short register queue of jobs between front and back end
// depends on btil_pkg for the job type and depth

module btil_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  btil_pkg::job_type wr_job,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output btil_pkg::job_type rd_job
);
   import btil_pkg::*;

   localparam int PTR_W = $clog2(JOB_Q_DEPTH);
   localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

   job_type           slot_ff [JOB_Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(JOB_Q_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !(rd_en && rd_valid)) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!wr_en && rd_en && rd_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (rd_en && rd_valid) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full))
      else $error("job written into a full queue");
`endif

endmodule

// File: src/btil_back.sv
// btil_back: expands each job into one result per set bit, lowest first, or an end marker
// depends on btil_pkg; holds the result in an output register

module btil_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  btil_pkg::job_type job,
   output logic              job_pop,
   output logic              empty,
   input  logic              pop,
   output btil_pkg::rsp_type rsp_data
);
   import btil_pkg::*;

   job_type cur_ff;
   logic    cur_valid_ff;
   rsp_type out_ff, out_in;
   logic    out_valid_ff;

   logic       can_issue, issue_done, marker;
   logic [2:0] sel;
   logic [7:0] rest;

   // lowest set bit of the remaining mask
   always_comb begin
      sel = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (cur_ff.mask[j]) begin
            sel = 3'(j);
         end
      end
   end

   assign rest       = cur_ff.mask & (cur_ff.mask - 8'd1);
   assign marker     = (cur_ff.mask == 8'd0);
   assign can_issue  = cur_valid_ff && (!out_valid_ff || pop);
   assign issue_done = can_issue && (marker || (rest == 8'd0));
   assign job_pop    = job_valid && (!cur_valid_ff || issue_done);

   always_comb begin
      out_in.surface_index  = marker ? '0 : cur_ff.base + INDEX_BITS'(sel);
      out_in.has_index      = !marker;
      out_in.run_last       = marker || (rest == 8'd0);
      out_in.section_done   = cur_ff.last && (marker || (rest == 8'd0));
      out_in.index_overflow = cur_ff.ovf;
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end else if (can_issue) begin
         cur_ff.mask <= rest;
      end
      if (can_issue) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            cur_valid_ff <= 1'b1;
         end else if (issue_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (can_issue) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef SYNTH
   a_job_continues: assert property (@(posedge clock) disable iff (reset)
      can_issue && !issue_done |=> cur_valid_ff)
      else $error("job dropped before its last result");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (!cur_valid_ff || issue_done))
      else $error("job loaded over one still in progress");
`endif

endmodule

// File: tb/tb_bitmap_to_index_list_decoder.sv
`timescale 1ns / 100ps
// tb_bitmap_to_index_list_decoder: self-checking testbench for the bitmap to index list decoder
// depends on btil_pkg and bitmap_to_index_list_decoder; drives bitmap bytes, predicts and
// checks every surface index and end marker through both modes, saturation and back-pressure

module tb_bitmap_to_index_list_decoder;
   import btil_pkg::*;

   localparam int unsigned INDEX_LIMIT     = 1 << INDEX_BITS;
   localparam logic        MODE_PLAIN      = 1'b0;
   localparam logic        MODE_COMPRESSED = 1'b1;
   localparam int          SETTLE_CYCLES   = 16;
   localparam int          DRAIN_LIMIT     = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_wdata;

   bitmap_to_index_list_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // decoder state as the testbench sees it, updated at each accepted transaction
   int unsigned next_base           = 0;
   logic        skip_armed          = 1'b0;   // next byte is a zero-run count
   logic        range_exceeded      = 1'b0;   // an index left the range in this section
   logic        run_mode_compressed = 1'b1;   // compressed_mode comes out of reset as 1

   rsp_type expected_indices[$];

   // bookkeeping for the summary and the verdict
   int error_count       = 0;
   int bytes_sent        = 0;
   int results_seen      = 0;
   int markers_seen      = 0;
   int overflow_marks    = 0;
   int full_stall_cycles = 0;

   // sender pacing: bursts of random length, random gaps, or no gaps at all
   int   burst_left    = 0;
   logic steady_sender = 1'b0;

   // long receiver hold-off, handed to the result sink which counts it down
   int hold_request = 0;

   // ---------------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------------

   // saturating advance of the base index, flags overflow when it would pass the limit
   function automatic void bump_base(input int unsigned amount);
      int unsigned sum;
      sum = next_base + amount;
      if (sum > INDEX_LIMIT) begin
         sum            = INDEX_LIMIT;
         range_exceeded = 1'b1;
      end
      next_base = sum;
   endfunction

   // one accepted byte: update state and queue every result it causes, in order
   function automatic void decode_byte(input logic [7:0] bits, input logic last);
      logic [INDEX_BITS-1:0] hits[8];
      int                    n;
      int unsigned           idx;
      rsp_type               r;
      n = 0;
      if (skip_armed) begin
         // count byte wins over the current mode and never emits
         skip_armed = 1'b0;
         bump_base(int'(bits) * BYTE_SPAN);
      end else if (bits == 8'h00) begin
         if (run_mode_compressed) begin
            // a zero at section end has no count to follow, so it is dropped
            if (!last) skip_armed = 1'b1;
         end else begin
            bump_base(BYTE_SPAN);
         end
      end else begin
         for (int j = 0; j < 8; j++) begin
            if (bits[j]) begin
               idx = next_base + j;
               if (idx >= INDEX_LIMIT) range_exceeded = 1'b1;
               else begin
                  hits[n] = idx[INDEX_BITS-1:0];
                  n++;
               end
            end
         end
         bump_base(BYTE_SPAN);
      end

      if (n == 0 && last) begin
         // section closes with nothing to show: lone end marker
         r                = '0;
         r.run_last       = 1'b1;
         r.section_done   = 1'b1;
         r.index_overflow = range_exceeded;
         expected_indices.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.surface_index  = hits[k];
            r.has_index      = 1'b1;
            r.run_last       = (k == n - 1);
            r.section_done   = (k == n - 1) && last;
            r.index_overflow = range_exceeded;
            expected_indices.push_back(r);
         end
      end

      if (last) begin
         next_base      = 0;
         skip_armed     = 1'b0;
         range_exceeded = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // result checking: every popped transaction against the oldest expectation
   // ---------------------------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (!rsp_data.has_index) markers_seen++;
         if (rsp_data.index_overflow) overflow_marks++;
         if (expected_indices.size() == 0) begin
            $error("result with nothing expected: surface_index %0d has_index %0b",
                   rsp_data.surface_index, rsp_data.has_index);
            error_count++;
         end else begin
            want = expected_indices.pop_front();
            check_field("surface_index", want.surface_index, rsp_data.surface_index);
            check_field("has_index", want.has_index, rsp_data.has_index);
            check_field("run_last", want.run_last, rsp_data.run_last);
            check_field("section_done", want.section_done, rsp_data.section_done);
            check_field("index_overflow", want.index_overflow, rsp_data.index_overflow);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // result sink: pop on a stall pattern of its own, plus long hold-offs on request
   // ---------------------------------------------------------------------------------------

   initial begin : result_sink
      int phase_left;
      int stall_pct;
      int hold_left;
      pop        <= 1'b0;
      phase_left = 0;
      stall_pct  = 0;
      hold_left  = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (phase_left == 0) begin
            // pick a new stall density: free-running, light, heavy or nearly blocked
            phase_left = $urandom_range(20, 120);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 30;
               3:       stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------------------------

   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 15);
         if (!steady_sender) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // offer one byte and hold it until the decoder takes the transaction
   task automatic send_byte(input logic [7:0] bits, input logic last);
      req_data <= req_type'{data_byte: bits, section_end: last};
      push     <= 1'b1;
      @(posedge clock);
      while (full) begin
         full_stall_cycles++;
         @(posedge clock);
      end
      decode_byte(bits, last);
      bytes_sent++;
      pace_sender();
   endtask

   // all expected results in, then wait SETTLE_CYCLES so the back end is clear
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_indices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_compression(input logic mode);
      wait_idle();
      csr_wdata <= mode;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      run_mode_compressed = mode;
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // plain bitmap: single low and high bits, a zero byte, a full byte, a mixed closing
   // byte, then a section that is only a zero byte and ends in a marker
   task automatic test_plain_bitmap();
      set_compression(MODE_PLAIN);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h00, 1'b1);
   endtask

   // compressed runs: zero count, largest count, trailing zero dropped at section end,
   // count byte that closes a section, one-byte section with indices
   task automatic test_compressed_runs();
      set_compression(MODE_COMPRESSED);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h07, 1'b1);
      send_byte(8'hC3, 1'b1);
   endtask

   // a pending count survives a switch to plain mode and is still taken as a count
   task automatic test_count_across_mode_write();
      set_compression(MODE_COMPRESSED);
      send_byte(8'h00, 1'b0);
      set_compression(MODE_PLAIN);
      send_byte(8'h03, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h00, 1'b1);
   endtask

   // skip close to the top of the index range, emit the highest indices up to the limit,
   // then run past it: a byte whose set bits are out of range, a skip that saturates the
   // base, and a dropped trailing zero that closes the section with a flagged marker
   task automatic test_index_saturation();
      int pairs;
      pairs = INDEX_LIMIT / (255 * BYTE_SPAN);
      set_compression(MODE_COMPRESSED);
      for (int i = 0; i < pairs; i++) begin
         send_byte(8'h00, 1'b0);
         send_byte(8'hFF, 1'b0);
      end
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b1);
      // next section starts from zero with the flag cleared
      send_byte(8'h01, 1'b1);
   endtask

   // receiver holds off for a long stretch while full bytes keep coming: the job queue
   // fills and the input has to stall until the sink lets go
   task automatic test_result_hold_off();
      set_compression(MODE_PLAIN);
      steady_sender = 1'b1;
      hold_request  = 400;
      for (int i = 0; i < 40; i++)
         send_byte((i % 5 == 4) ? 8'(($urandom_range(1, 255))) : 8'hFF, (i % 8) == 7);
      steady_sender = 1'b0;
   endtask

   // random sections in both modes: mostly well-formed sections whose zero bytes in
   // compressed mode are followed by a count, plus bursts of raw noise
   task automatic test_random_sections();
      int          phase_items;
      int          len;
      logic [7:0]  bits;
      logic        last;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_compression(MODE_COMPRESSED);
            1:       set_compression(MODE_PLAIN);
            default: set_compression(logic'($urandom_range(0, 1)));
         endcase
         steady_sender = (phase % 3 == 2);
         phase_items   = 0;
         while (phase_items < 35) begin
            if ($urandom_range(0, 9) < 8) begin
               len = $urandom_range(1, 10);
               for (int i = 0; i < len; i++) begin
                  last = (i == len - 1);
                  if (skip_armed) begin
                     // counts are mostly short, sometimes anything up to the largest
                     if ($urandom_range(0, 3) == 0) bits = 8'($urandom_range(0, 255));
                     else                           bits = 8'($urandom_range(0, 4));
                  end else begin
                     case ($urandom_range(0, 5))
                        0:       bits = 8'h00;
                        1:       bits = 8'hFF;
                        2:       bits = 8'h01 << $urandom_range(0, 7);
                        default: bits = 8'($urandom_range(0, 255));
                     endcase
                  end
                  send_byte(bits, last);
               end
            end else begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++)
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            phase_items += len;
         end
      end
      // close whatever section is open so nothing is left pending
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      steady_sender = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // run control
   // ---------------------------------------------------------------------------------------

   initial begin : run_tests
      int drain;
      push      <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_bitmap();
      test_compressed_runs();
      test_count_across_mode_write();
      test_index_saturation();
      test_result_hold_off();
      test_random_sections();

      // drain: every expected transaction must come out, then nothing more may follow
      push <= 1'b0;
      drain = 0;
      while (expected_indices.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_indices.size() != 0) begin
         $error("%0d expected results never arrived", expected_indices.size());
         error_count++;
      end

      $display("sent %0d bitmap bytes in both modes; checked %0d results, %0d end markers,",
               bytes_sent, results_seen, markers_seen);
      $display("%0d with overflow; input stalled on a full queue for %0d cycles",
               overflow_marks, full_stall_cycles);
      if (error_count == 0) $display("RESULT: OK");
      else                  $display("RESULT: ERROR");
      $finish;
   end

   // generous ceiling, far above the slowest legal run
   initial begin : watchdog
      #(5_000_000);
      $display("timeout with %0d results still expected", expected_indices.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
src/btil_pkg.sv
src/btil_front.sv
src/btil_job_fifo.sv
src/btil_back.sv
src/bitmap_to_index_list_decoder.sv
tb/tb_bitmap_to_index_list_decoder.sv
